/* sv/ovf_pkg.sv */
// Shared types, constants and the arctangent table of the obstacle visibility filter.
package ovf_pkg;

	// Datapath word widths
	localparam int CW        = 36;   // CORDIC x/y word, 8 guard bits
	localparam int PW        = 61;   // product of CORDIC word and gain
	localparam int ZW        = 32;   // angle accumulator, 2^32 per turn
	localparam int STEPS     = 24;
	localparam int STEP_W    = 5;

	localparam logic signed [24:0] K_GAIN     = 25'sd10188012;  // 1/1.6468 in Q24
	localparam logic [23:0]        MIN_RANGE  = 24'd13;         // 0.05 m
	localparam logic [16:0]        BRG_WINDOW = 17'd910;        // 5 degrees
	localparam logic [24:0]        OCC_GAP    = 25'd512;        // 2 m

	// Configuration register indexes
	localparam logic [1:0] REG_MAX_RANGE = 2'd0;
	localparam logic [1:0] REG_HALF_FOV  = 2'd1;
	localparam logic [1:0] REG_OCC_EN    = 2'd2;

	localparam logic [23:0] MAX_RANGE_RST = 24'd15360;
	localparam logic [15:0] HALF_FOV_RST  = 16'd10923;

	// Buffered obstacle
	typedef struct packed {
		logic [3:0]         idx;
		logic signed [23:0] rel_x;
		logic signed [23:0] rel_y;
		logic [23:0]        rng;
		logic signed [15:0] brg;
	} entry_t;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE, ST_ROT_INIT, ST_ROT, ST_MUL_X, ST_MUL_Y, ST_FIN_Y,
		ST_VEC_INIT, ST_VEC, ST_MUL_R, ST_GATE, ST_FE_INIT,
		ST_P_CHK_I, ST_P_LAT_I, ST_P_CHK_J, ST_P_CMP,
		ST_E_START, ST_E_NONE, ST_E_CHK, ST_E_LD
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_in;
		logic rot_init;
		logic rot_step;
		logic mul_x;
		logic mul_y;
		logic fin_y;
		logic vec_init;
		logic vec_step;
		logic mul_r;
		logic gate;
		logic keep_all;
		logic rd_i;
		logic rd_j;
		logic lat_i;
		logic drop_i;
		logic out_load;
		logic out_none;
		logic clear;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic full;
		logic last_item;
		logic cordic_done;
		logic occ_en;
		logic keep_i;
		logic keep_j;
		logic hit;
		logic any_kept;
		logic more_after_i;
		logic out_free;
	} status_t;

	// atan(2^-i) in 2^32 per turn
	function automatic logic [ZW-1:0] atan_val(input logic [STEP_W-1:0] i);
		logic [ZW-1:0] r;
		begin
			case (i)
				5'd0:  r = 32'd536870912;
				5'd1:  r = 32'd316933406;
				5'd2:  r = 32'd167458907;
				5'd3:  r = 32'd85004756;
				5'd4:  r = 32'd42667331;
				5'd5:  r = 32'd21354465;
				5'd6:  r = 32'd10679838;
				5'd7:  r = 32'd5340245;
				5'd8:  r = 32'd2670163;
				5'd9:  r = 32'd1335087;
				5'd10: r = 32'd667544;
				5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;
				5'd13: r = 32'd83443;
				5'd14: r = 32'd41722;
				5'd15: r = 32'd20861;
				5'd16: r = 32'd10430;
				5'd17: r = 32'd5215;
				5'd18: r = 32'd2608;
				5'd19: r = 32'd1304;
				5'd20: r = 32'd652;
				5'd21: r = 32'd326;
				5'd22: r = 32'd163;
				5'd23: r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage

/* sv/obstacle_visibility_filter.sv */
// Top level of the obstacle visibility filter.
// Each accepted word is one obstacle of a frame. It is rotated into the vehicle frame by a
// 24-step CORDIC, converted to range and bearing by a second 24-step CORDIC on the same
// shift-add unit, scaled by a shared gain multiplier and gated; the two CORDIC passes run
// at one step per cycle. On the word marked last the buffered obstacles are pruned pairwise,
// if occlusion pruning is enabled, from a buffer with a single read port, then each kept
// obstacle is read out into the output register, or one none-visible word if none is kept.
// The input is stalled from acceptance until the obstacle is processed, and across the
// pruning and read-out of a frame; a held result word does not stall the next input word
// once the frame is finished.
module obstacle_visibility_filter #(
	parameter int MAX_OBSTACLES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] obstacle_x,
	input  logic signed [23:0] obstacle_y,
	input  logic signed [23:0] ref_x,
	input  logic signed [23:0] ref_y,
	input  logic [15:0]        heading,
	input  logic               last_obstacle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         obstacle_index,
	output logic signed [23:0] rel_x,
	output logic signed [23:0] rel_y,
	output logic [23:0]        range,
	output logic signed [15:0] bearing,
	output logic               none_visible,
	output logic               last_result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import ovf_pkg::*;

	localparam int IW = $clog2(MAX_OBSTACLES + 1);

	cmd_t          cmd;
	status_t       status;
	logic [IW-1:0] vc, i_idx, j_idx;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	ovf_ctrl #(
		.MAX_OBSTACLES (MAX_OBSTACLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status),
		.vc       (vc),
		.i_idx    (i_idx),
		.j_idx    (j_idx)
	);

	ovf_dp #(
		.MAX_OBSTACLES (MAX_OBSTACLES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.vc             (vc),
		.i_idx          (i_idx),
		.j_idx          (j_idx),
		.obstacle_x     (obstacle_x),
		.obstacle_y     (obstacle_y),
		.ref_x          (ref_x),
		.ref_y          (ref_y),
		.heading        (heading),
		.last_obstacle  (last_obstacle),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.obstacle_index (obstacle_index),
		.rel_x          (rel_x),
		.rel_y          (rel_y),
		.range          (range),
		.bearing        (bearing),
		.none_visible   (none_visible),
		.last_result    (last_result)
	);
endmodule

/* sv/ovf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ovf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

/* sv/ovf_dp.sv */
// Datapath: CORDIC unit, gain multiplier, gating, obstacle buffer, pruning and output register.
module ovf_dp #(
	parameter int MAX_OBSTACLES = 16,
	parameter int IW = $clog2(MAX_OBSTACLES + 1),
	parameter int AW = $clog2(MAX_OBSTACLES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ovf_pkg::cmd_t         cmd,
	output ovf_pkg::status_t      status,
	output logic [IW-1:0]         vc,
	input  logic [IW-1:0]         i_idx,
	input  logic [IW-1:0]         j_idx,
	input  logic signed [23:0]    obstacle_x,
	input  logic signed [23:0]    obstacle_y,
	input  logic signed [23:0]    ref_x,
	input  logic signed [23:0]    ref_y,
	input  logic [15:0]           heading,
	input  logic                  last_obstacle,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [23:0]           cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [3:0]            obstacle_index,
	output logic signed [23:0]    rel_x,
	output logic signed [23:0]    rel_y,
	output logic [23:0]           range,
	output logic signed [15:0]    bearing,
	output logic                  none_visible,
	output logic                  last_result
);
	import ovf_pkg::*;

	localparam int EW = $bits(entry_t);

	// configuration
	logic [23:0] max_range_q;
	logic [15:0] half_fov_q;
	logic        occ_en_q;

	// CORDIC and product state
	logic signed [CW-1:0] x_q, y_q, xg_q, yg_q;
	logic [ZW-1:0]        z_q;
	logic [STEP_W-1:0]    cnt_q;
	logic signed [PW-1:0] p_q;
	logic                 last_q;
	logic [3:0]           idx_q;

	// frame counters and flags
	logic [IW-1:0]            vc_q, received_q;
	logic [MAX_OBSTACLES-1:0] keep_q;
	logic [23:0]              ri_q;
	logic signed [15:0]       bi_q;

	// output register
	logic       o_valid_q;
	entry_t     o_entry_q;
	logic       o_none_q, o_last_q;

	// combinational
	logic signed [24:0]   dx, dy;
	logic signed [CW-1:0] xs, ys;
	logic [ZW-1:0]        atan_c;
	logic signed [CW-1:0] mul_a;
	logic signed [PW+0:0] p_ext, p_rnd24, p_rnd32;
	logic signed [CW-1:0] xg_c;
	logic signed [29:0]   rng_w;
	logic [23:0]          rng_c;
	logic [ZW-1:0]        z_rnd;
	logic signed [15:0]   brg_c;
	logic [16:0]          brg_mag;
	logic signed [CW:0]   rx_sum, ry_sum;
	logic signed [28:0]   rx_sh, ry_sh;
	logic                 pass;
	logic                 wr_en;
	entry_t               wr_entry, rd_entry;
	logic [EW-1:0]        rd_raw;
	logic [IW+3:0]        recv_ext;
	logic signed [16:0]   bdiff;
	logic [16:0]          bdiff_abs;
	logic [MAX_OBSTACLES-1:0] below_vc, above_i;
	logic [AW-1:0]        i_addr, j_addr, vc_addr;

	assign i_addr  = i_idx[AW-1:0];
	assign j_addr  = j_idx[AW-1:0];
	assign vc_addr = vc_q[AW-1:0];
	assign vc      = vc_q;

	function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
		logic signed [23:0] r;
		begin
			if (v > 29'sd8388607) begin
				r = 24'sh7FFFFF;
			end else if (v < -29'sd8388608) begin
				r = -24'sd8388608;
			end else begin
				r = v[23:0];
			end
			return r;
		end
	endfunction

	// CORDIC step operands
	always_comb begin
		dx     = 25'(obstacle_x) - 25'(ref_x);
		dy     = 25'(obstacle_y) - 25'(ref_y);
		xs     = x_q >>> cnt_q;
		ys     = y_q >>> cnt_q;
		atan_c = atan_val(cnt_q);
	end

	// gain multiplier operand select and rounding of the product
	always_comb begin
		if (cmd.mul_y) begin
			mul_a = y_q;
		end else begin
			mul_a = x_q;
		end
		p_ext   = {p_q[PW-1], p_q};
		p_rnd24 = p_ext + ((PW+1)'(1) <<< 23);
		p_rnd32 = p_ext + ((PW+1)'(1) <<< 31);
		xg_c    = p_rnd24[CW+23:24];
		rng_w   = p_rnd32[61:32];
		if (rng_w[29]) begin
			rng_c = 24'd0;
		end else if (|rng_w[28:24]) begin
			rng_c = 24'hFFFFFF;
		end else begin
			rng_c = rng_w[23:0];
		end
	end

	// bearing, relative position and visibility gate
	always_comb begin
		z_rnd   = z_q + 32'h0000_8000;
		brg_c   = z_rnd[31:16];
		brg_mag = brg_c[15] ? (17'd0 - {1'b1, brg_c}) : {1'b0, brg_c};
		rx_sum  = {xg_q[CW-1], xg_q} + (CW+1)'(128);
		ry_sum  = {yg_q[CW-1], yg_q} + (CW+1)'(128);
		rx_sh   = 29'(rx_sum >>> 8);
		ry_sh   = 29'(ry_sum >>> 8);
		pass    = (rng_c <= max_range_q) && (rng_c >= MIN_RANGE)
			&& (brg_mag <= {1'b0, half_fov_q});
		wr_en   = cmd.gate && pass && (vc_q < IW'(MAX_OBSTACLES));
		recv_ext = {4'd0, received_q};
		wr_entry.idx   = idx_q;
		wr_entry.rel_x = sat24(rx_sh);
		wr_entry.rel_y = sat24(ry_sh);
		wr_entry.rng   = rng_c;
		wr_entry.brg   = brg_c;
	end

	// obstacle buffer
	ovf_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_OBSTACLES)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (vc_addr),
		.wr_data (wr_entry),
		.rd_en   (cmd.rd_i || cmd.rd_j),
		.rd_addr (cmd.rd_i ? i_addr : j_addr),
		.rd_data (rd_raw)
	);
	assign rd_entry = entry_t'(rd_raw);

	// occlusion test and keep-flag masks
	always_comb begin
		bdiff     = {bi_q[15], bi_q} - {rd_entry.brg[15], rd_entry.brg};
		bdiff_abs = bdiff[16] ? 17'(-bdiff) : 17'(bdiff);
		for (int k = 0; k < MAX_OBSTACLES; k++) begin
			below_vc[k] = IW'(k) < vc_q;
			above_i[k]  = IW'(k) > i_idx;
		end
	end

	always_comb begin
		status.full         = received_q >= IW'(MAX_OBSTACLES);
		status.last_item    = last_q;
		status.cordic_done  = cnt_q == STEP_W'(STEPS - 1);
		status.occ_en       = occ_en_q;
		status.keep_i       = keep_q[i_addr];
		status.keep_j       = keep_q[j_addr];
		status.hit          = (bdiff_abs < BRG_WINDOW)
			&& ({1'b0, rd_entry.rng} + OCC_GAP < {1'b0, ri_q});
		status.any_kept     = |(keep_q & below_vc);
		status.more_after_i = |(keep_q & below_vc & above_i);
		status.out_free     = !o_valid_q || !out_stall;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_range_q <= MAX_RANGE_RST;
			half_fov_q  <= HALF_FOV_RST;
			occ_en_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_RANGE: max_range_q <= cfg_data;
				REG_HALF_FOV:  half_fov_q  <= cfg_data[15:0];
				REG_OCC_EN:    occ_en_q    <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// frame counters and output valid; a word counts once it has been gated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q       <= '0;
			received_q <= '0;
			o_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				vc_q       <= '0;
				received_q <= '0;
			end else begin
				if (cmd.gate) begin
					received_q <= received_q + IW'(1);
				end
				if (wr_en) begin
					vc_q <= vc_q + IW'(1);
				end
			end
			if (cmd.out_load) begin
				o_valid_q <= 1'b1;
			end else if (!out_stall) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	// CORDIC, multiplier and pruning registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q    <= {{3{dx[24]}}, dx, 8'd0};
			y_q    <= {{3{dy[24]}}, dy, 8'd0};
			z_q    <= 32'd0 - {heading, 16'd0};
			last_q <= last_obstacle;
			idx_q  <= recv_ext[3:0];
		end
		if (cmd.rot_init) begin
			cnt_q <= '0;
			if (z_q[31:30] == 2'd1 || z_q[31:30] == 2'd2) begin
				x_q <= -x_q;
				y_q <= -y_q;
				z_q <= z_q + 32'h8000_0000;
			end
		end
		if (cmd.rot_step) begin
			cnt_q <= cnt_q + STEP_W'(1);
			if (!z_q[31]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_c;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_c;
			end
		end
		if (cmd.mul_x || cmd.mul_y || cmd.mul_r) begin
			p_q <= PW'(mul_a * K_GAIN);
		end
		if (cmd.mul_y) begin
			xg_q <= xg_c;
		end
		if (cmd.fin_y) begin
			yg_q <= xg_c;
		end
		if (cmd.vec_init) begin
			cnt_q <= '0;
			if (xg_q < 0) begin
				x_q <= -xg_q;
				y_q <= -yg_q;
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= xg_q;
				y_q <= yg_q;
				z_q <= 32'd0;
			end
		end
		if (cmd.vec_step) begin
			cnt_q <= cnt_q + STEP_W'(1);
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_c;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_c;
			end
		end
		if (cmd.keep_all) begin
			keep_q <= '1;
		end else if (cmd.drop_i) begin
			keep_q[i_addr] <= 1'b0;
		end
		if (cmd.lat_i) begin
			ri_q <= rd_entry.rng;
			bi_q <= rd_entry.brg;
		end
		if (cmd.out_load) begin
			o_none_q <= cmd.out_none;
			o_last_q <= cmd.out_none || !status.more_after_i;
			o_entry_q <= cmd.out_none ? entry_t'('0) : rd_entry;
		end
	end

	assign out_valid      = o_valid_q;
	assign obstacle_index = o_entry_q.idx;
	assign rel_x          = o_entry_q.rel_x;
	assign rel_y          = o_entry_q.rel_y;
	assign range          = o_entry_q.rng;
	assign bearing        = o_entry_q.brg;
	assign none_visible   = o_none_q;
	assign last_result    = o_last_q;

`ifndef SYNTH
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> vc_q < IW'(MAX_OBSTACLES))
		else $error("buffer written beyond its depth");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("output word overwritten while held");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> o_valid_q)
		else $error("loaded word not presented");
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && o_none_q) |-> o_last_q)
		else $error("empty-frame word not marked last");
`endif
endmodule

/* sv/ovf_ctrl.sv */
// Controller: sequences the CORDIC passes, gating, pruning and emission of a frame.
module ovf_ctrl #(
	parameter int MAX_OBSTACLES = 16,
	parameter int IW = $clog2(MAX_OBSTACLES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output ovf_pkg::cmd_t    cmd,
	input  ovf_pkg::status_t status,
	input  logic [IW-1:0]    vc,
	output logic [IW-1:0]    i_idx,
	output logic [IW-1:0]    j_idx
);
	import ovf_pkg::*;

	state_t        state_q, state_d;
	logic [IW-1:0] i_q, j_q;
	logic          i_inc, i_clr, j_inc, j_clr;
	logic          in_acc;

	assign in_stall = state_q != ST_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign i_idx    = i_q;
	assign j_idx    = j_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_ROT_INIT;
				end
			end
			ST_ROT_INIT: begin
				// a frame that has already received its maximum number of words skips processing
				if (status.full) begin
					state_d = status.last_item ? ST_FE_INIT : ST_IDLE;
				end else begin
					state_d = ST_ROT;
				end
			end
			ST_ROT:      state_d = status.cordic_done ? ST_MUL_X : ST_ROT;
			ST_MUL_X:    state_d = ST_MUL_Y;
			ST_MUL_Y:    state_d = ST_FIN_Y;
			ST_FIN_Y:    state_d = ST_VEC_INIT;
			ST_VEC_INIT: state_d = ST_VEC;
			ST_VEC:      state_d = status.cordic_done ? ST_MUL_R : ST_VEC;
			ST_MUL_R:    state_d = ST_GATE;
			ST_GATE:     state_d = status.last_item ? ST_FE_INIT : ST_IDLE;
			ST_FE_INIT:  state_d = status.occ_en ? ST_P_CHK_I : ST_E_START;
			ST_P_CHK_I: begin
				if (i_q == vc) begin
					state_d = ST_E_START;
				end else if (status.keep_i) begin
					state_d = ST_P_LAT_I;
				end
			end
			ST_P_LAT_I:  state_d = ST_P_CHK_J;
			ST_P_CHK_J: begin
				if (j_q == vc) begin
					state_d = ST_P_CHK_I;
				end else if (j_q != i_q && status.keep_j) begin
					state_d = ST_P_CMP;
				end
			end
			ST_P_CMP:    state_d = status.hit ? ST_P_CHK_I : ST_P_CHK_J;
			ST_E_START:  state_d = status.any_kept ? ST_E_CHK : ST_E_NONE;
			ST_E_NONE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_E_CHK: begin
				if (i_q == vc) begin
					state_d = ST_IDLE;
				end else if (status.keep_i) begin
					state_d = ST_E_LD;
				end
			end
			ST_E_LD: begin
				if (status.out_free) begin
					state_d = ST_E_CHK;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd   = '0;
		i_inc = 1'b0;
		i_clr = 1'b0;
		j_inc = 1'b0;
		j_clr = 1'b0;
		case (state_q)
			ST_IDLE:     cmd.load_in  = in_acc;
			ST_ROT_INIT: cmd.rot_init = !status.full;
			ST_ROT:      cmd.rot_step = 1'b1;
			ST_MUL_X:    cmd.mul_x    = 1'b1;
			ST_MUL_Y:    cmd.mul_y    = 1'b1;
			ST_FIN_Y:    cmd.fin_y    = 1'b1;
			ST_VEC_INIT: cmd.vec_init = 1'b1;
			ST_VEC:      cmd.vec_step = 1'b1;
			ST_MUL_R:    cmd.mul_r    = 1'b1;
			ST_GATE:     cmd.gate     = 1'b1;
			ST_FE_INIT: begin
				cmd.keep_all = 1'b1;
				i_clr        = 1'b1;
			end
			ST_P_CHK_I: begin
				if (i_q != vc) begin
					if (status.keep_i) begin
						cmd.rd_i = 1'b1;
					end else begin
						i_inc = 1'b1;
					end
				end
			end
			ST_P_LAT_I: begin
				cmd.lat_i = 1'b1;
				j_clr     = 1'b1;
			end
			ST_P_CHK_J: begin
				if (j_q == vc) begin
					i_inc = 1'b1;
				end else if (j_q != i_q && status.keep_j) begin
					cmd.rd_j = 1'b1;
				end else begin
					j_inc = 1'b1;
				end
			end
			ST_P_CMP: begin
				if (status.hit) begin
					cmd.drop_i = 1'b1;
					i_inc      = 1'b1;
				end else begin
					j_inc = 1'b1;
				end
			end
			ST_E_START:  i_clr = 1'b1;
			ST_E_NONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_none = 1'b1;
					cmd.clear    = 1'b1;
				end
			end
			ST_E_CHK: begin
				if (i_q == vc) begin
					cmd.clear = 1'b1;
				end else if (status.keep_i) begin
					cmd.rd_i = 1'b1;
				end else begin
					i_inc = 1'b1;
				end
			end
			ST_E_LD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					i_inc        = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (i_clr) begin
				i_q <= '0;
			end else if (i_inc) begin
				i_q <= i_q + IW'(1);
			end
			if (j_clr) begin
				j_q <= '0;
			end else if (j_inc) begin
				j_q <= j_q + IW'(1);
			end
		end
	end

`ifndef SYNTH
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P_CHK_I || state_q == ST_E_CHK) |-> i_q <= vc)
		else $error("obstacle index ran past the buffered count");
	a_rd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_i && cmd.rd_j))
		else $error("two buffer reads in one cycle");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> state_q == ST_ROT_INIT)
		else $error("accepted word not processed");
`endif
endmodule

/* tb/sv/obstacle_visibility_filter_tb.sv */
// Self-checking testbench of the obstacle visibility filter: directed and random frames against a built-in predictor.
module obstacle_visibility_filter_tb;
	import ovf_pkg::*;

	localparam int MAX_OBS   = 16;
	localparam int CYC_LIMIT = 900000;
	// register index outside the list, ignored by the block
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [23:0] ox;
		logic signed [23:0] oy;
		logic signed [23:0] rx;
		logic signed [23:0] ry;
		logic [15:0]        hdg;
		logic               last;
	} obstacle_t;

	typedef struct packed {
		logic [3:0]         idx;
		logic signed [23:0] rel_x;
		logic signed [23:0] rel_y;
		logic [23:0]        rng;
		logic signed [15:0] brg;
		logic               none;
		logic               last;
	} track_t;

	// Configuration change queued behind a frame boundary
	typedef struct packed {
		logic [1:0]  idx;
		logic [23:0] data;
	} cfg_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [23:0] obstacle_x = '0, obstacle_y = '0, ref_x = '0, ref_y = '0;
	logic [15:0] heading = '0;
	logic last_obstacle = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] obstacle_index;
	logic signed [23:0] rel_x, rel_y;
	logic [23:0] range;
	logic signed [15:0] bearing;
	logic none_visible, last_result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	obstacle_visibility_filter #(.MAX_OBSTACLES(MAX_OBS)) u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state
	logic [23:0] p_max_range = MAX_RANGE_RST;
	logic [15:0] p_half_fov = HALF_FOV_RST;
	logic        p_occ_en = 1'b1;
	track_t      frame_buf[MAX_OBS];
	int          n_visible = 0, n_received = 0;

	obstacle_t pending_words[$];
	track_t    expected_tracks[$];
	int        errors = 0;
	int        cycles = 0;
	bit        stim_done = 1'b0;
	bit        idle_on = 1'b1;
	int        hold_off = 0;
	// phase boundaries: config writes applied after the word count reaches each mark
	int        cfg_mark[$];
	cfg_word_t cfg_words[$];
	int        words_sent = 0;

	function automatic longint asr64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [23:0] sat24(longint v);
		if (v > 8388607) return 24'sh7FFFFF;
		if (v < -8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic logic [31:0] atan_step(int i);
		logic [31:0] t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return t[i];
	endfunction

	// Transform, gate and buffer one obstacle
	task automatic locate_obstacle(obstacle_t w);
		longint x, y, xs, ys, xg, yg, rg;
		logic [31:0] z;
		logic [15:0] b16;
		int brg, mag;
		x = (longint'(w.ox) - longint'(w.rx)) * 256;
		y = (longint'(w.oy) - longint'(w.ry)) * 256;
		z = 32'd0 - {w.hdg, 16'd0};
		if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
			x = -x; y = -y; z = z + 32'h80000000;
		end
		for (int i = 0; i < 24; i++) begin
			xs = asr64(x, i); ys = asr64(y, i);
			if (!z[31]) begin
				x -= ys; y += xs; z -= atan_step(i);
			end else begin
				x += ys; y -= xs; z += atan_step(i);
			end
		end
		xg = asr64(x * 10188012 + (64'sd1 << 23), 24);
		yg = asr64(y * 10188012 + (64'sd1 << 23), 24);
		x = xg; y = yg; z = 32'd0;
		if (x < 0) begin
			x = -x; y = -y; z = 32'h80000000;
		end
		for (int i = 0; i < 24; i++) begin
			xs = asr64(x, i); ys = asr64(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_step(i);
			end else begin
				x -= ys; y += xs; z -= atan_step(i);
			end
		end
		rg = asr64(x * 10188012 + (64'sd1 << 31), 32);
		if (rg < 0) rg = 0;
		if (rg > 64'hFFFFFF) rg = 64'hFFFFFF;
		b16 = 16'((z + 32'h8000) >> 16);
		brg = $signed(b16);
		mag = brg < 0 ? -brg : brg;
		if (rg > longint'(p_max_range) || rg < 13) return;
		if (mag > int'(p_half_fov)) return;
		if (n_visible >= MAX_OBS) return;
		frame_buf[n_visible] = '{idx: 4'(n_received), rel_x: sat24(asr64(xg + 128, 8)),
			rel_y: sat24(asr64(yg + 128, 8)), rng: rg[23:0], brg: b16, none: 1'b0, last: 1'b0};
		n_visible++;
	endtask

	// Accept one obstacle word; at frame end prune and queue the expected tracks
	task automatic take_obstacle(obstacle_t w);
		bit keep[MAX_OBS];
		int d, last_k;
		track_t t;
		if (n_received < MAX_OBS) begin
			locate_obstacle(w);
			n_received++;
		end
		if (!w.last) return;
		last_k = -1;
		for (int i = 0; i < n_visible; i++) keep[i] = 1'b1;
		if (p_occ_en) begin
			for (int i = 0; i < n_visible; i++) begin
				if (!keep[i]) continue;
				for (int j = 0; j < n_visible; j++) begin
					if (i == j || !keep[j]) continue;
					d = int'(frame_buf[i].brg) - int'(frame_buf[j].brg);
					if (d < 0) d = -d;
					if (d < 910 && int'(frame_buf[j].rng) + 512 < int'(frame_buf[i].rng)) begin
						keep[i] = 1'b0;
						break;
					end
				end
			end
		end
		for (int i = 0; i < n_visible; i++) if (keep[i]) last_k = i;
		if (last_k < 0) begin
			t = '0; t.none = 1'b1; t.last = 1'b1;
			expected_tracks.push_back(t);
		end else begin
			for (int i = 0; i < n_visible; i++) begin
				if (!keep[i]) continue;
				t = frame_buf[i];
				t.last = (i == last_k);
				expected_tracks.push_back(t);
			end
		end
		n_visible = 0;
		n_received = 0;
	endtask

	function automatic obstacle_t rand_obstacle(bit last);
		obstacle_t w;
		int r;
		w.rx = 24'($urandom);
		w.ry = 24'($urandom);
		w.hdg = 16'($urandom);
		w.last = last;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			// near the reference, mostly ahead within a few tens of metres
			w.ox = w.rx + 24'($signed($urandom_range(0, 16000)) - 4000);
			w.oy = w.ry + 24'($signed($urandom_range(0, 12000)) - 6000);
			w.hdg = 16'($urandom_range(0, 3000)) - 16'd1500;
			if (r == 6) w.hdg = 16'($urandom);
		end else begin
			w.ox = 24'($urandom);
			w.oy = 24'($urandom);
		end
		return w;
	endfunction

	// Random frame; about one word in three is placed near one bearing at varying depth to form occluded clusters
	task automatic push_frame(int n);
		obstacle_t w;
		for (int i = 0; i < n; i++) begin
			w = rand_obstacle(i == n - 1);
			if ($urandom_range(0, 2) == 0) begin
				w.rx = 0; w.ry = 0; w.hdg = 0;
				w.ox = 24'($urandom_range(500, 14000));
				w.oy = 24'($signed($urandom_range(0, 200)) - 100);
			end
			pending_words.push_back(w);
		end
	endtask

	task automatic push_word(logic signed [23:0] ox, oy, rx, ry, logic [15:0] h, bit last);
		pending_words.push_back('{ox: ox, oy: oy, rx: rx, ry: ry, hdg: h, last: last});
	endtask

	task automatic queue_cfg(logic [1:0] idx, logic [23:0] data);
		cfg_mark.push_back(pending_words.size());
		cfg_words.push_back('{idx: idx, data: data});
	endtask

	// Stimulus build
	initial begin
		// directed: extremes, occlusion pair, empty frame, wrap of heading
		push_word(24'sd2560, 0, 0, 0, 16'd0, 1'b0);
		push_word(24'sd3584, 24'sd10, 0, 0, 16'd0, 1'b0);
		push_word(24'sd1000, 24'sd1000, 0, 0, 16'd0, 1'b1);
		push_word(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 16'hFFFF, 1'b1);
		push_word(24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 16'h8000, 1'b1);
		push_word(24'sd5, 0, 0, 0, 16'd0, 1'b1);
		push_word(24'sd13, 0, 0, 0, 16'd0, 1'b0);
		push_word(-24'sd2000, 24'sd100, 0, 0, 16'h8000, 1'b0);
		push_word(0, 24'sd2000, 0, 0, 16'h4000, 1'b0);
		push_word(0, -24'sd2000, 0, 0, 16'hC000, 1'b1);
		// over-long frame: 18 words, last two beyond the buffer
		for (int i = 0; i < 18; i++)
			push_word(24'(1000 + 300 * i), 24'(40 * i), 0, 0, 16'd0, i == 17);
		// wide field of view, no pruning, maximal range
		queue_cfg(REG_HALF_FOV, 24'd32768);
		queue_cfg(REG_OCC_EN, 24'd0);
		queue_cfg(REG_MAX_RANGE, 24'hFFFFFF);
		for (int f = 0; f < 8; f++) push_frame($urandom_range(1, 6));
		// narrowest settings
		queue_cfg(REG_HALF_FOV, 24'd0);
		queue_cfg(REG_MAX_RANGE, 24'd0);
		for (int f = 0; f < 4; f++) push_frame($urandom_range(1, 4));
		// back to defaults with random register values in between
		queue_cfg(REG_OCC_EN, 24'd1);
		queue_cfg(REG_MAX_RANGE, 24'($urandom_range(3000, 20000)));
		queue_cfg(REG_HALF_FOV, 24'($urandom_range(2000, 20000)));
		queue_cfg(REG_UNUSED, 24'($urandom));
		while (pending_words.size() < 250) push_frame($urandom_range(1, 8));
		queue_cfg(REG_MAX_RANGE, MAX_RANGE_RST);
		queue_cfg(REG_HALF_FOV, HALF_FOV_RST);
		while (pending_words.size() < 380) push_frame($urandom_range(1, 17));
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Cycle count, idle profile and the long receiver hold-off
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 20000) idle_on <= 1'b0;
		if (cycles == 60000) idle_on <= 1'b1;
		if (cycles == 3000) hold_off <= 400;
		else if (hold_off > 0) hold_off <= hold_off - 1;
		if (cycles >= CYC_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Input and configuration driver
	int   settle = 0;
	always @(posedge clk) begin
		obstacle_t w;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_RANGE: p_max_range = cfg_data;
					REG_HALF_FOV:  p_half_fov = cfg_data[15:0];
					REG_OCC_EN:    p_occ_en = cfg_data[0];
					default: ;
				endcase
				cfg_valid <= 1'b0;
			end else if (in_valid && !in_stall) begin
				take_obstacle('{ox: obstacle_x, oy: obstacle_y, rx: ref_x, ry: ref_y,
					hdg: heading, last: last_obstacle});
				words_sent++;
				in_valid <= 1'b0;
			end else if (!in_valid && !cfg_valid) begin
				if (cfg_mark.size() > 0 && cfg_mark[0] <= words_sent) begin
					// let the block drain before touching a register
					if (expected_tracks.size() != 0 || n_received != 0) settle = 0;
					else if (settle < 200) settle++;
					else begin
						cfg_index <= cfg_words[0].idx;
						cfg_data <= cfg_words[0].data;
						cfg_valid <= 1'b1;
						void'(cfg_mark.pop_front());
						void'(cfg_words.pop_front());
						settle = 0;
					end
				end else if (pending_words.size() > 0) begin
					if (!idle_on || $urandom_range(0, 99) >= 36) begin
						w = pending_words.pop_front();
						obstacle_x <= w.ox; obstacle_y <= w.oy;
						ref_x <= w.rx; ref_y <= w.ry;
						heading <= w.hdg; last_obstacle <= w.last;
						in_valid <= 1'b1;
					end
				end else begin
					stim_done = 1'b1;
				end
			end
		end
	end

	// Output stall driver
	always @(posedge clk) begin
		out_stall <= (hold_off > 1) || (idle_on && $urandom_range(0, 99) < 36);
	end

	// Result monitor
	always @(posedge clk) begin
		track_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tracks.size() == 0) begin
				$error("unexpected result word index %0d", obstacle_index);
				errors++;
			end else begin
				e = expected_tracks.pop_front();
				if (obstacle_index !== e.idx) begin
					$error("obstacle_index exp %0d got %0d", e.idx, obstacle_index); errors++;
				end
				if (rel_x !== e.rel_x) begin
					$error("rel_x exp %0d got %0d", e.rel_x, rel_x); errors++;
				end
				if (rel_y !== e.rel_y) begin
					$error("rel_y exp %0d got %0d", e.rel_y, rel_y); errors++;
				end
				if (range !== e.rng) begin
					$error("range exp %0d got %0d", e.rng, range); errors++;
				end
				if (bearing !== e.brg) begin
					$error("bearing exp %0d got %0d", e.brg, bearing); errors++;
				end
				if (none_visible !== e.none) begin
					$error("none_visible exp %0b got %0b", e.none, none_visible); errors++;
				end
				if (last_result !== e.last) begin
					$error("last_result exp %0b got %0b", e.last, last_result); errors++;
				end
			end
		end
	end

	// End of run
	initial begin
		wait (stim_done && expected_tracks.size() == 0);
		repeat (600) @(posedge clk);
		if (errors == 0 && expected_tracks.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
